### rtl/sha_pkg.sv
// package: types, round constants and a helper function for the sha-256 hasher
`default_nettype none
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  // controller to datapath
  typedef struct packed {
    logic       init_hash;   // load initial hash values
    logic       wr_byte;     // shift wr_data in and advance the fill position
    logic [7:0] wr_data;
    logic       clr_len;
    logic       add_len;     // bit count += 8
    logic       start_blk;   // load working vars and start rounds
    logic [2:0] out_sel;
  } sha_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       blk_done;    // pulse: compression of a block finished
    logic       busy;
    logic [5:0] fill;
    logic [7:0] len_byte;    // bit count byte chosen by fill[2:0]
  } sha_sts_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

### rtl/sha_datapath.sv
// datapath: byte shift-in, bit count, message schedule, round unit and hash words
`default_nettype none
module sha_datapath import sha_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire sha_cmd_t cmd,
  output sha_sts_t      sts,
  output logic [31:0]   hash_word
);

  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] len_r, len_nxt;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [5:0]  rnd_r, rnd_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  logic [31:0] wt, t1, t2, wnew, s0, s1, e, a;

  assign e  = v_r[4];
  assign a  = v_r[0];
  assign wt = w_r[0];
  assign s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign wnew = s1 + w_r[9] + s0 + w_r[0];
  assign t1 = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
            + ((e & v_r[5]) ^ (~e & v_r[6])) + ROUND_K[rnd_r] + wt;
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
            + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));

  always_comb begin
    fill_nxt = fill_r;
    len_nxt  = len_r;
    rnd_nxt  = rnd_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.wr_byte) fill_nxt = fill_r + 6'd1;
    if (cmd.add_len) len_nxt = len_r + 64'd8;
    if (cmd.clr_len) len_nxt = '0;
    if (cmd.start_blk) begin
      busy_nxt = 1'b1;
      rnd_nxt  = '0;
    end else if (busy_r) begin
      rnd_nxt = rnd_r + 6'd1;
      if (rnd_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      len_r  <= '0;
      rnd_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      len_r  <= len_nxt;
      rnd_r  <= rnd_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init_hash) begin
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_HASH[i];
    end else if (busy_r && rnd_r == 6'd63) begin
      h_r[0] <= h_r[0] + t1 + t2;
      h_r[1] <= h_r[1] + v_r[0];
      h_r[2] <= h_r[2] + v_r[1];
      h_r[3] <= h_r[3] + v_r[2];
      h_r[4] <= h_r[4] + v_r[3] + t1;
      h_r[5] <= h_r[5] + v_r[4];
      h_r[6] <= h_r[6] + v_r[5];
      h_r[7] <= h_r[7] + v_r[6];
    end
    if (cmd.start_blk) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (busy_r) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
    // bytes shift in at the bottom, so a full block leaves byte 0 on top of word 0
    if (cmd.wr_byte) begin
      for (int i = 0; i < 15; i++) w_r[i] <= {w_r[i][23:0], w_r[i+1][31:24]};
      w_r[15] <= {w_r[15][23:0], cmd.wr_data};
    end else if (busy_r) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wnew;
    end
  end

  assign sts.blk_done = done_r;
  assign sts.busy     = busy_r;
  assign sts.fill     = fill_r;
  assign sts.len_byte = len_r[8*(7 - fill_r[2:0]) +: 8];
  assign hash_word    = h_r[cmd.out_sel];

endmodule
`default_nettype wire

### rtl/sha_ctrl.sv
// controller: byte intake, padding sequence and digest output
`default_nettype none
module sha_ctrl import sha_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire sha_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output sha_out_t      out_data,
  input  wire sha_sts_t sts,
  input  wire logic [31:0] hash_word,
  output sha_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COMP = 3'd1;  // compress during intake
  localparam logic [2:0] S_PAD  = 3'd2;  // pad byte
  localparam logic [2:0] S_ZERO = 3'd3;
  localparam logic [2:0] S_LEN  = 3'd4;
  localparam logic [2:0] S_PCMP = 3'd5;  // compress during finish
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] ret_r, ret_nxt;     // where to go after finish compression
  logic [2:0] idx_r, idx_nxt;
  logic       fin_r, fin_nxt;     // pending finish after intake compression

  logic acc;
  assign in_ready = (state_r == S_IDLE);
  assign acc = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    idx_nxt   = idx_r;
    fin_nxt   = fin_r;
    cmd       = '0;
    cmd.out_sel = idx_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_data.has_byte) begin
            cmd.wr_byte = 1'b1;
            cmd.wr_data = in_data.data_byte;
            cmd.add_len = 1'b1;
          end
          fin_nxt = in_data.last_of_message;
          if (in_data.has_byte && sts.fill == 6'd63) begin
            cmd.start_blk = 1'b1;
            state_nxt = S_COMP;
          end else if (in_data.last_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_COMP: begin
        if (sts.blk_done) state_nxt = fin_r ? S_PAD : S_IDLE;
      end
      S_PAD: begin
        cmd.wr_byte = 1'b1;
        cmd.wr_data = PAD_BYTE;
        if (sts.fill == 6'd63) begin
          cmd.start_blk = 1'b1;
          ret_nxt = S_ZERO;
          state_nxt = S_PCMP;
        end else begin
          state_nxt = (sts.fill + 6'd1 == LEN_POS) ? S_LEN : S_ZERO;
        end
      end
      S_ZERO: begin
        if (sts.fill == LEN_POS) begin
          state_nxt = S_LEN;
        end else begin
          cmd.wr_byte = 1'b1;
          cmd.wr_data = '0;
          if (sts.fill == 6'd63) begin
            cmd.start_blk = 1'b1;
            ret_nxt = S_ZERO;
            state_nxt = S_PCMP;
          end
        end
      end
      S_LEN: begin
        cmd.wr_byte = 1'b1;
        cmd.wr_data = sts.len_byte;
        if (sts.fill == 6'd63) begin
          cmd.start_blk = 1'b1;
          ret_nxt = S_OUT;
          state_nxt = S_PCMP;
        end
      end
      S_PCMP: begin
        if (sts.blk_done) begin
          state_nxt = ret_r;
          idx_nxt = '0;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.init_hash = 1'b1;
            cmd.clr_len = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      idx_r   <= '0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      idx_r   <= idx_nxt;
      fin_r   <= fin_nxt;
    end
  end

  assign out_valid = (state_r == S_OUT);
  assign out_data.digest_word = hash_word;
  assign out_data.word_index  = idx_r;
  assign out_data.last_word   = (idx_r == 3'd7);

endmodule
`default_nettype wire

### rtl/sha256_message_hasher_core.sv
// top level of the sha-256 message hasher
//
// input channel: one request per message byte (in_data.data_byte with
//   has_byte set); last_of_message closes the message, with or without a byte
// output channel: eight digest words, word 0 (most significant) first,
//   last_word marks word 7
// throughput: bytes are taken one per cycle while in_ready is high; the 64th
//   byte of a block starts a compression of 64 rounds, one per cycle in the
//   shared round unit, and no request is taken until the done pulse of that
//   compression has reached the controller
// finish: pad byte, zeros and the eight length bytes are written one a cycle,
//   with a step that writes nothing when the zeros reach byte 56 (none when
//   the pad byte lands on byte 55); there are one or two padded blocks, each
//   compressed in the shared round unit; the first digest word is offered when
//   the last one is done, then one word per cycle while out_ready is high
// a stalled receiver holds the current word; no request is taken until
//   all eight words have gone, after which a new message starts at once
// reset (synchronous, rst_n low) loads the initial hash values and clears
//   the fill position and bit count; the message words are not cleared
`default_nettype none
module sha256_message_hasher_core import sha_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire sha_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output sha_out_t     out_data
);

  sha_cmd_t    cmd;
  sha_sts_t    sts;
  logic [31:0] hash_word;

  // sequencer for intake, padding and digest output
  sha_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .sts, .hash_word, .cmd
  );

  // byte shift-in, schedule and round unit
  sha_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .hash_word
  );

endmodule
`default_nettype wire

### verif/tb_top.sv
// sha-256 hasher testbench: directed and random messages, checked against a built-in digest model
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import sha_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  sha_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  sha_out_t out_data;

  sha256_message_hasher_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // idling phases
  typedef enum int {PH_NONE, PH_SEND, PH_RECV, PH_BOTH} idle_phase_e;

  // digest model state
  logic [31:0] hw [8];
  logic [7:0]  blk [64];
  int          fill;
  logic [63:0] bitlen;

  sha_in_t  pending_reqs [$];
  sha_out_t digest_expect [$];
  int          mismatches;
  idle_phase_e phase;
  int          hold_cycles;   // receiver hold-off, counted down by its own process
  bit          drain_pause;   // sender waits for all expected words

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_blk();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    {a, b, c, d, e, f, g, h} = {hw[0], hw[1], hw[2], hw[3], hw[4], hw[5], hw[6], hw[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_K[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hw[0] += a; hw[1] += b; hw[2] += c; hw[3] += d;
    hw[4] += e; hw[5] += f; hw[6] += g; hw[7] += h;
  endtask

  task automatic append_byte(logic [7:0] v);
    blk[fill] = v;
    fill++;
    if (fill == 64) begin
      compress_blk();
      fill = 0;
    end
  endtask

  task automatic hash_restart();
    for (int i = 0; i < 8; i++) hw[i] = INIT_HASH[i];
    fill = 0;
    bitlen = '0;
  endtask

  // feeds one accepted request into the model
  task automatic hash_request(sha_in_t r);
    logic [63:0] len;
    sha_out_t    o;
    if (r.has_byte) begin
      append_byte(r.data_byte);
      bitlen += 64'd8;
    end
    if (r.last_of_message) begin
      len = bitlen;
      append_byte(PAD_BYTE);
      while (fill != LEN_POS) append_byte(8'h00);
      for (int i = 0; i < 8; i++) append_byte(len[63-8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        o.digest_word = hw[i];
        o.word_index  = 3'(i);
        o.last_word   = (i == 7);
        digest_expect.push_back(o);
      end
      hash_restart();
    end
  endtask

  function automatic sha_in_t mk_req(logic [7:0] d, bit hb, bit lm);
    sha_in_t r;
    r.data_byte = d; r.has_byte = hb; r.last_of_message = lm;
    return r;
  endfunction

  // queues a message of n bytes; end item carries the final byte or none
  task automatic queue_message(int n, bit end_with_byte, bit fixed, logic [7:0] fv);
    int body;
    body = end_with_byte && n > 0 ? n - 1 : n;
    for (int i = 0; i < body; i++) begin
      if ($urandom_range(0, 19) == 0)
        pending_reqs.push_back(mk_req(8'($urandom), 1'b0, 1'b0));   // empty request
      pending_reqs.push_back(mk_req(fixed ? fv : 8'($urandom), 1'b1, 1'b0));
    end
    if (end_with_byte && n > 0)
      pending_reqs.push_back(mk_req(fixed ? fv : 8'($urandom), 1'b1, 1'b1));
    else
      pending_reqs.push_back(mk_req(8'($urandom), 1'b0, 1'b1));
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  // driver: offers requests from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid && in_ready) hash_request(in_data);
      if (pending_reqs.size() != 0 && !drain_pause &&
          !((phase == PH_SEND && $urandom_range(0, 99) < 48) ||
            (phase == PH_BOTH && $urandom_range(0, 99) < 10))) begin
        in_data  <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver ready, with optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= !((phase == PH_RECV && $urandom_range(0, 99) < 48) ||
                     (phase == PH_BOTH && $urandom_range(0, 99) < 10));
    end
  end

  // monitor: compares each digest word with the oldest expectation
  always @(posedge clk) begin
    sha_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (digest_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest word %h idx %0d", out_data.digest_word,
                   out_data.word_index);
      end else begin
        want = digest_expect.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                     want.digest_word, want.word_index, want.last_word,
                     out_data.digest_word, out_data.word_index, out_data.last_word);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || digest_expect.size() != 0)
      @(posedge clk);
  endtask

  // short random messages; the block and padding boundaries are covered by the directed messages
  task automatic random_messages(int count);
    int n;
    for (int m = 0; m < count; m++) begin
      case ($urandom_range(0, 9))
        0: n = 0;
        default: n = $urandom_range(1, 8);
      endcase
      queue_message(n, $urandom_range(0, 1), 1'b0, 8'h00);
    end
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; out_ready = 1'b0; in_data = '0;
    mismatches = 0; hold_cycles = 0; drain_pause = 1'b0;
    phase = PH_NONE;
    hash_restart();
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty message, extremes, boundary lengths, ignored request
    pending_reqs.push_back(mk_req(8'hff, 1'b0, 1'b0));
    queue_message(0, 1'b0, 1'b0, 8'h00);
    queue_message(1, 1'b1, 1'b1, 8'h00);
    queue_message(2, 1'b0, 1'b1, 8'hff);
    queue_message(3, 1'b1, 1'b1, 8'h5a);
    queue_message(4, 1'b1, 1'b1, 8'ha5);
    wait_drained();
    queue_message(55, 1'b1, 1'b0, 8'h00);
    queue_message(56, 1'b0, 1'b0, 8'h00);
    queue_message(64, 1'b1, 1'b0, 8'h00);
    wait_drained();

    // random phases
    for (int p = 0; p < 4; p++) begin
      phase = idle_phase_e'(p);
      random_messages(2);
      if (p == 1) begin
        // long receiver hold-off while the sender keeps going
        hold_cycles = 400;
        random_messages(1);
      end
      wait_drained();
      // sender pause until everything has come back
      drain_pause = 1'b1;
      wait_drained();
      drain_pause = 1'b0;
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0 && digest_expect.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire

### sha256_message_hasher_core.f
rtl/sha_pkg.sv
rtl/sha_datapath.sv
rtl/sha_ctrl.sv
rtl/sha256_message_hasher_core.sv
verif/tb_top.sv
